/* hw/rtl/pftq_pkg.sv */
package pftq_pkg;

   localparam int FILE_BITS   = 16;
   localparam int PAGE_BITS   = 16;
   localparam int STAMP_BITS  = 32;
   localparam int QUOTA_BITS  = 6;
   localparam int FRAME_BITS  = 5;
   localparam int FREED_BITS  = 6;

   localparam logic [QUOTA_BITS-1:0] QUOTA_RESET = 6'd4;

   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [FILE_BITS-1:0] file_id;
      logic [PAGE_BITS-1:0] page_number;
   } req_word_type;

   typedef struct packed {
      logic                  hit;
      logic [FRAME_BITS-1:0] frame_index;
      logic                  replaced;
      logic [PAGE_BITS-1:0]  replaced_page;
      logic [FREED_BITS-1:0] freed_count;
   } rsp_word_type;

endpackage

/* hw/rtl/page_frame_table_lru_quota.sv */
// Page frame table with a per-file quota and oldest-allocation replacement.
// An access word looks up (file_id, page_number); on a miss a frame is taken
// from the file's own oldest when it holds its quota, else the lowest free
// frame, else the oldest frame overall. A delete word frees all frames of a
// file. Each word is scanned before the next is accepted: the entry memory
// is read one frame per cycle through its single read port, then a finish
// state decides and writes back. The result sits in an output register, so
// a new word is taken while the previous result waits. No clearing pass is
// needed after reset; frame valid bits are flip-flops cleared by reset.
// csr_word sets the quota; it is to be only written while the block is idle,
// which the block itself does not enforce.
module page_frame_table_lru_quota
   import pftq_pkg::*;
#(
   parameter int FRAME_COUNT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [QUOTA_BITS-1:0] csr_word
);

   localparam int IDX_BITS = $clog2(FRAME_COUNT);
   localparam int CNT_BITS = $clog2(FRAME_COUNT + 1);
   localparam int CMP_BITS = (CNT_BITS > QUOTA_BITS) ? CNT_BITS : QUOTA_BITS;
   localparam int OUT_BITS = (IDX_BITS > FRAME_BITS) ? IDX_BITS : FRAME_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(FRAME_COUNT - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   typedef struct packed {
      logic [FILE_BITS-1:0]  file_id;
      logic [PAGE_BITS-1:0]  page;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   entry_type entry_mem [FRAME_COUNT];
   entry_type rd_data_ff;
   logic      rd_valid_ff;
   logic      mem_we;
   logic [IDX_BITS-1:0] mem_waddr;
   entry_type           mem_wdata;

   logic [FRAME_COUNT-1:0] valid_ff, valid_in;
   logic [1:0]             state_ff, state_in;
   logic [STAMP_BITS-1:0]  stamp_ff, stamp_in;
   logic [QUOTA_BITS-1:0]  quota_ff, quota_in;
   req_word_type           req_ff, req_in;
   rsp_word_type           rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [IDX_BITS-1:0] addr_ff, addr_in;
   logic                issue_ff, issue_in;
   logic                proc_ff, proc_in;
   logic [IDX_BITS-1:0] proc_idx_ff, proc_idx_in;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   found_idx_ff, found_idx_in;
   logic                  free_ok_ff, free_ok_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                  fbest_ok_ff, fbest_ok_in;
   logic [IDX_BITS-1:0]   fbest_idx_ff, fbest_idx_in;
   logic [STAMP_BITS-1:0] fbest_age_ff, fbest_age_in;
   logic [PAGE_BITS-1:0]  fbest_page_ff, fbest_page_in;
   logic                  gbest_ok_ff, gbest_ok_in;
   logic [IDX_BITS-1:0]   gbest_idx_ff, gbest_idx_in;
   logic [STAMP_BITS-1:0] gbest_age_ff, gbest_age_in;
   logic [PAGE_BITS-1:0]  gbest_page_ff, gbest_page_in;

   logic                  match;
   logic [STAMP_BITS-1:0] age;
   logic [CMP_BITS-1:0]   count_w, quota_w;
   logic [IDX_BITS-1:0]   slot;
   logic                  repl;
   logic [PAGE_BITS-1:0]  repl_page;
   logic [OUT_BITS-1:0]   slot_w;
   logic                  out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      rd_data_ff  <= entry_mem[addr_ff];
      rd_valid_ff <= valid_ff[addr_ff];
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
   end

   assign match = rd_valid_ff && (rd_data_ff.file_id == req_ff.file_id);
   assign age   = stamp_ff - rd_data_ff.stamp;
   assign count_w = CMP_BITS'(count_ff);
   assign quota_w = (quota_ff == '0) ? CMP_BITS'(1) : CMP_BITS'(quota_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (count_w >= quota_w) begin
         slot      = fbest_idx_ff;
         repl      = 1'b1;
         repl_page = fbest_page_ff;
      end else if (free_ok_ff) begin
         slot      = free_idx_ff;
         repl      = 1'b0;
         repl_page = '0;
      end else begin
         slot      = gbest_idx_ff;
         repl      = 1'b1;
         repl_page = gbest_page_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      stamp_in      = stamp_ff;
      quota_in      = quota_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      proc_in       = 1'b0;
      proc_idx_in   = addr_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      fbest_ok_in   = fbest_ok_ff;
      fbest_idx_in  = fbest_idx_ff;
      fbest_age_in  = fbest_age_ff;
      fbest_page_in = fbest_page_ff;
      gbest_ok_in   = gbest_ok_ff;
      gbest_idx_in  = gbest_idx_ff;
      gbest_age_in  = gbest_age_ff;
      gbest_page_in = gbest_page_ff;
      mem_we        = 1'b0;
      mem_waddr     = slot;
      mem_wdata     = '{file_id: req_ff.file_id, page: req_ff.page_number, stamp: stamp_ff};
      slot_w        = OUT_BITS'(slot);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         quota_in = csr_word;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_word;
               addr_in     = '0;
               issue_in    = 1'b1;
               count_in    = '0;
               found_in    = 1'b0;
               free_ok_in  = 1'b0;
               fbest_ok_in = 1'b0;
               gbest_ok_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               proc_in = 1'b1;
               if (addr_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (proc_ff) begin
               if (match) begin
                  count_in = count_ff + 1'b1;
                  if (req_ff.kind == KIND_DELETE) begin
                     valid_in[proc_idx_ff] = 1'b0;
                  end
                  if (!found_ff && rd_data_ff.page == req_ff.page_number) begin
                     found_in     = 1'b1;
                     found_idx_in = proc_idx_ff;
                  end
                  if (!fbest_ok_ff || age > fbest_age_ff) begin
                     fbest_ok_in   = 1'b1;
                     fbest_idx_in  = proc_idx_ff;
                     fbest_age_in  = age;
                     fbest_page_in = rd_data_ff.page;
                  end
               end
               if (rd_valid_ff) begin
                  if (!gbest_ok_ff || age > gbest_age_ff) begin
                     gbest_ok_in   = 1'b1;
                     gbest_idx_in  = proc_idx_ff;
                     gbest_age_in  = age;
                     gbest_page_in = rd_data_ff.page;
                  end
               end else if (!free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = proc_idx_ff;
               end
               if (proc_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = ST_IDLE;
               if (req_ff.kind == KIND_DELETE) begin
                  rsp_in.freed_count = count_w[FREED_BITS-1:0];
               end else if (found_ff) begin
                  slot_w              = OUT_BITS'(found_idx_ff);
                  rsp_in.hit          = 1'b1;
                  rsp_in.frame_index  = slot_w[FRAME_BITS-1:0];
               end else begin
                  mem_we               = 1'b1;
                  valid_in[slot]       = 1'b1;
                  stamp_in             = stamp_ff + 1'b1;
                  rsp_in.frame_index   = slot_w[FRAME_BITS-1:0];
                  rsp_in.replaced      = repl;
                  rsp_in.replaced_page = repl_page;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         stamp_ff     <= '0;
         quota_ff     <= QUOTA_RESET;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         proc_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         stamp_ff     <= stamp_in;
         quota_ff     <= quota_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         proc_ff      <= proc_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      addr_ff       <= addr_in;
      proc_idx_ff   <= proc_idx_in;
      count_ff      <= count_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      fbest_ok_ff   <= fbest_ok_in;
      fbest_idx_ff  <= fbest_idx_in;
      fbest_age_ff  <= fbest_age_in;
      fbest_page_ff <= fbest_page_in;
      gbest_ok_ff   <= gbest_ok_in;
      gbest_idx_ff  <= gbest_idx_in;
      gbest_age_ff  <= gbest_age_in;
      gbest_page_ff <= gbest_page_in;
   end

endmodule

/* hw/rtl/pftq_checker.sv */
module pftq_checker
   import pftq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_word_type          rsp_word
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // one word at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in flight");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.hit |-> !rsp_word.replaced && rsp_word.freed_count == '0)
      else $error("hit word reports eviction or freed frames");

   a_delete_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.freed_count != '0
         |-> !rsp_word.hit && !rsp_word.replaced && rsp_word.frame_index == '0
             && rsp_word.replaced_page == '0)
      else $error("delete word carries access fields");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind page_frame_table_lru_quota pftq_checker u_pftq_checker (.*);

/* dv/page_frame_table_lru_quota_checker.sv */
`timescale 1ns / 1ps
module page_frame_table_lru_quota_checker
   import pftq_pkg::*;
#(
   parameter int FRAME_COUNT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_word_type          req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_word_type          rsp_word,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [QUOTA_BITS-1:0] csr_word,
   output int                    outstanding,
   output int                    fail_count
);

   logic                  frame_live  [FRAME_COUNT];
   logic [FILE_BITS-1:0]  frame_file  [FRAME_COUNT];
   logic [PAGE_BITS-1:0]  frame_page  [FRAME_COUNT];
   logic [STAMP_BITS-1:0] frame_stamp [FRAME_COUNT];
   logic [STAMP_BITS-1:0] alloc_stamp;
   logic [QUOTA_BITS-1:0] quota;
   rsp_word_type          pending_results [$];
   int                    mismatches = 0;

   function automatic int oldest_frame(bit owner_only, logic [FILE_BITS-1:0] owner);
      int                    best;
      logic [STAMP_BITS-1:0] best_age;
      logic [STAMP_BITS-1:0] age;
      best     = -1;
      best_age = '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         age = alloc_stamp - frame_stamp[i];
         if (frame_live[i] && (!owner_only || frame_file[i] == owner) &&
             (best < 0 || age > best_age)) begin
            best     = i;
            best_age = age;
         end
      end
      return best;
   endfunction

   // updates the frame table for one word and returns the result it yields
   function automatic rsp_word_type table_outcome(req_word_type w);
      rsp_word_type r;
      int           owned;
      int           found;
      int           slot;
      int           limit;
      r     = '0;
      owned = 0;
      found = -1;
      slot  = -1;
      limit = (quota == 0) ? 1 : int'(quota);
      if (w.kind == KIND_DELETE) begin
         for (int i = 0; i < FRAME_COUNT; i++) begin
            if (frame_live[i] && frame_file[i] == w.file_id) begin
               frame_live[i]  = 1'b0;
               r.freed_count = r.freed_count + 1'b1;
            end
         end
      end else begin
         for (int i = 0; i < FRAME_COUNT; i++) begin
            if (frame_live[i] && frame_file[i] == w.file_id) begin
               owned++;
               if (found < 0 && frame_page[i] == w.page_number) found = i;
            end
         end
         if (found >= 0) begin
            r.hit         = 1'b1;
            r.frame_index = found[FRAME_BITS-1:0];
         end else begin
            if (owned >= limit) begin
               slot       = oldest_frame(1'b1, w.file_id);
               r.replaced = 1'b1;
            end else begin
               for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
                  if (!frame_live[i]) slot = i;
               end
               if (slot < 0) begin
                  slot       = oldest_frame(1'b0, '0);
                  r.replaced = 1'b1;
               end
            end
            if (r.replaced) r.replaced_page = frame_page[slot];
            frame_live[slot]  = 1'b1;
            frame_file[slot]  = w.file_id;
            frame_page[slot]  = w.page_number;
            frame_stamp[slot] = alloc_stamp;
            alloc_stamp       = alloc_stamp + 1'b1;
            r.frame_index     = slot[FRAME_BITS-1:0];
         end
      end
      return r;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         for (int i = 0; i < FRAME_COUNT; i++) begin
            frame_live[i]  = 1'b0;
            frame_file[i]  = '0;
            frame_page[i]  = '0;
            frame_stamp[i] = '0;
         end
         alloc_stamp = '0;
         quota       = QUOTA_RESET;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) quota = csr_word;
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: expected no word, actual %p", $time, rsp_word);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               compare_field("hit", 32'(want.hit), 32'(rsp_word.hit));
               compare_field("frame_index", 32'(want.frame_index),
                             32'(rsp_word.frame_index));
               compare_field("replaced", 32'(want.replaced), 32'(rsp_word.replaced));
               compare_field("replaced_page", 32'(want.replaced_page),
                             32'(rsp_word.replaced_page));
               compare_field("freed_count", 32'(want.freed_count),
                             32'(rsp_word.freed_count));
            end
         end
         if (req_valid && req_ready) begin
            pending_results.insert(pending_results.size(), table_outcome(req_word));
         end
      end
      outstanding <= pending_results.size();
      fail_count  <= mismatches;
   end

endmodule

/* dv/page_frame_table_lru_quota_tb.sv */
`timescale 1ns / 1ps
module page_frame_table_lru_quota_tb;
   import pftq_pkg::*;

   localparam int FRAME_COUNT     = 32;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 148;
   localparam int POOL_SIZE       = 10;
   localparam int QUIET_LIMIT     = 400;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [QUOTA_BITS-1:0] csr_word  = '0;

   int                    outstanding;
   int                    fail_count;
   int                    quiet_cycles = 0;
   bit                    idle_on = 1'b1;
   logic [FILE_BITS-1:0]  file_pool [POOL_SIZE];
   logic [QUOTA_BITS-1:0] quota_plan [PHASES];

   page_frame_table_lru_quota #(
      .FRAME_COUNT(FRAME_COUNT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_word (csr_word)
   );

   page_frame_table_lru_quota_checker #(
      .FRAME_COUNT(FRAME_COUNT)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_word   (csr_word),
      .outstanding(outstanding),
      .fail_count (fail_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_word_type make_word(logic kind, logic [FILE_BITS-1:0] file_id,
                                              logic [PAGE_BITS-1:0] page_number);
      req_word_type w;
      w.kind        = kind;
      w.file_id     = file_id;
      w.page_number = page_number;
      return w;
   endfunction

   // mostly a small set of files and pages so hits, quota and global evictions occur
   function automatic req_word_type random_word();
      req_word_type w;
      w.kind = ($urandom_range(0, 9) == 0) ? KIND_DELETE : KIND_ACCESS;
      if ($urandom_range(0, 99) < 8) begin
         w.file_id     = FILE_BITS'($urandom);
         w.page_number = PAGE_BITS'($urandom);
      end else begin
         w.file_id     = file_pool[$urandom_range(0, POOL_SIZE - 1)];
         w.page_number = PAGE_BITS'($urandom_range(0, 11));
      end
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_quota(logic [QUOTA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_word  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_word_type directed [$];
      file_pool[0] = '0;
      file_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) file_pool[i] = FILE_BITS'($urandom);
      quota_plan    = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd4, 6'd5, 6'd4};
      quota_plan[6] = QUOTA_BITS'($urandom_range(1, 32));

      // delete of an unknown file, hit, extremes, quota eviction, frees
      directed.insert(directed.size(), make_word(KIND_DELETE, 16'h0000, 16'h0000));
      directed.insert(directed.size(), make_word(KIND_ACCESS, 16'h0000, 16'h0000));
      directed.insert(directed.size(), make_word(KIND_ACCESS, 16'h0000, 16'h0000));
      directed.insert(directed.size(), make_word(KIND_ACCESS, 16'hFFFF, 16'hFFFF));
      directed.insert(directed.size(), make_word(KIND_ACCESS, 16'hFFFF, 16'h0000));
      for (int p = 0; p < 5; p++) begin
         directed.insert(directed.size(), make_word(KIND_ACCESS, 16'h0001, PAGE_BITS'(p)));
      end
      directed.insert(directed.size(), make_word(KIND_ACCESS, 16'h0001, 16'h0000));
      directed.insert(directed.size(), make_word(KIND_ACCESS, 16'h0001, 16'h0004));
      directed.insert(directed.size(), make_word(KIND_DELETE, 16'h0001, 16'hFFFF));
      directed.insert(directed.size(), make_word(KIND_DELETE, 16'h0001, 16'h0000));
      directed.insert(directed.size(), make_word(KIND_DELETE, 16'hFFFF, 16'h0000));
      directed.insert(directed.size(), make_word(KIND_ACCESS, 16'h0000, 16'h0000));
      directed.insert(directed.size(), make_word(KIND_DELETE, 16'h0000, 16'h0000));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_word(directed[i]);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         write_quota(quota_plan[ph]);
         idle_on = (ph != 2) && (ph != PHASES - 1);
         repeat (WORDS_PER_PHASE) send_word(random_word());
      end

      drain();
      repeat (FRAME_COUNT + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
